// ===== rtl/core/joystick_direction_scanner_defines.svh =====
// Assertion macros for the joystick direction scanner.
// No dependencies; included by the top level only.
`ifndef JOYSTICK_DIRECTION_SCANNER_DEFINES_SVH
`define JOYSTICK_DIRECTION_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define JDS_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("jds assertion failed");
// condition must never be true outside reset
`define JDS_NEVER(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
		else $error("jds forbidden condition seen");
`else
`define JDS_ASSERT(lbl, clk_s, rst_n_s, prop)
`define JDS_NEVER(lbl, clk_s, rst_n_s, cond)
`endif

`endif

// ===== rtl/core/jds_pkg.sv =====
// Shared types and constants of the joystick direction scanner.
// No dependencies.
package jds_pkg;

	localparam int unsigned COL_W        = 5;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned BUTTON_LINES = 28;
	localparam int unsigned STICK_COLUMNS = 4;
	localparam int unsigned THR_W        = 19;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_H     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_V     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BTN_BASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BTN_TOTAL = 3'd6;

	localparam logic [15:0] RST_CENTER    = 16'd2048;
	localparam logic [15:0] RST_DEADZONE  = 16'd200;
	localparam logic [15:0] RST_HYST      = 16'd50;
	localparam logic [5:0]  RST_BTN_BASE  = 6'd4;
	localparam logic [4:0]  RST_BTN_TOTAL = 5'd0;

	typedef enum logic [1:0] {
		DIR_REST  = 2'b00,
		DIR_PLUS  = 2'b01,
		DIR_MINUS = 2'b10
	} jds_dir_t;

	typedef struct packed {
		logic [15:0] center;
		logic [15:0] deadzone;
		logic [15:0] hyst;
		logic        inv_h;
		logic        inv_v;
		logic [5:0]  btn_base;
		logic [4:0]  btn_total;
	} jds_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} jds_q_stat_t;

endpackage

// ===== rtl/core/jds_poll_if.sv =====
// Poll channel: valid/ready handshake carrying two samples and button levels.
// Depends on jds_pkg.
interface jds_poll_if import jds_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] x_sample;
	logic signed [SAMPLE_W-1:0] y_sample;
	logic [BUTTON_LINES-1:0]    button_levels;

	modport source (output valid, x_sample, y_sample, button_levels, input ready);
	modport sink   (input valid, x_sample, y_sample, button_levels, output ready);
endinterface

// ===== rtl/core/jds_event_if.sv =====
// Event channel: valid/ready handshake carrying one key change.
// Depends on jds_pkg.
interface jds_event_if import jds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column_index;
	logic             is_pressed;
	logic             last_event;

	modport source (output valid, column_index, is_pressed, last_event, input ready);
	modport sink   (input valid, column_index, is_pressed, last_event, output ready);
endinterface

// ===== rtl/core/joystick_direction_scanner.sv =====
// Channel   Dir   Payload
// poll      in    x_sample, y_sample, button_levels
// ev        out   column_index, is_pressed, last_event
// cfg       in    cfg_write_en, cfg_index, cfg_data (write only)
//
// The front end classifies a poll in the cycle it is taken, one poll per cycle unless the queue is full.
// The back end emits one event per cycle while its output slot is free, so a poll with k
// changes yields k events (up to MAX_COLUMNS); polls without reportable changes are not queued.
// A two-entry queue lets the front run ahead; poll.ready drops only when it fills.
// arst_n clears all control state at once; no clearing pass.
// Depends on jds_pkg, jds_poll_if, jds_event_if, jds_front, jds_queue, jds_back.
`include "joystick_direction_scanner_defines.svh"

module joystick_direction_scanner import jds_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	jds_poll_if.sink              poll,
	jds_event_if.source           ev
);

	logic                     q_push, q_pop;
	logic [MAX_COLUMNS-1:0]   push_report, push_level;
	logic [2*MAX_COLUMNS-1:0] head;
	jds_q_stat_t              q_stat;

	jds_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.poll        (poll),
		.q_stat      (q_stat),
		.push        (q_push),
		.push_report (push_report),
		.push_level  (push_level)
	);

	jds_queue #(.WIDTH(2 * MAX_COLUMNS), .DEPTH(2)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data({push_report, push_level}),
		.pop    (q_pop),
		.rd_data(head),
		.stat   (q_stat)
	);

	jds_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_report(head[2*MAX_COLUMNS-1:MAX_COLUMNS]),
		.head_level (head[MAX_COLUMNS-1:0]),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.ev         (ev)
	);

	`JDS_NEVER(a_no_overflow, clk, arst_n, q_push && q_stat.full)
	`JDS_NEVER(a_no_underflow, clk, arst_n, q_pop && q_stat.empty)
	`JDS_ASSERT(a_push_has_work, clk, arst_n, q_push |-> (push_report != '0))
	// more events of the same poll follow straight after a non-final one
	`JDS_ASSERT(a_burst_continues, clk, arst_n, (ev.valid && ev.ready && !ev.last_event) |=> ev.valid)

endmodule

// ===== rtl/core/jds_front.sv =====
// Front end: config registers, axis classification with hysteresis, column mask
// and change detection. Depends on jds_pkg and jds_poll_if.
module jds_front import jds_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	jds_poll_if.sink               poll,
	input  jds_q_stat_t            q_stat,
	output logic                   push,
	output logic [MAX_COLUMNS-1:0] push_report,
	output logic [MAX_COLUMNS-1:0] push_level
);

	jds_cfg_t               cfg_q;
	jds_dir_t               hdir_q, vdir_q;
	logic [MAX_COLUMNS-1:0] mask_q;

	logic signed [THR_W-1:0] c19, d19, h19;
	logic signed [THR_W-1:0] lo_rest, hi_rest, lo_move, hi_move;
	logic signed [THR_W-1:0] sx, sy;
	jds_dir_t               hx, vy, ex, ey;
	logic [STICK_COLUMNS-1:0] stick;
	logic [BUTTON_LINES-1:0]  btn_en;
	logic [63:0]              btn_wide;
	logic [6:0]               limit;
	logic [MAX_COLUMNS-1:0]   in_range;
	logic [MAX_COLUMNS-1:0]   next_mask;
	logic                     accept;

	function automatic jds_dir_t classify(
		input logic signed [THR_W-1:0] s,
		input jds_dir_t                prev,
		input logic signed [THR_W-1:0] lr, hr, lm, hm
	);
		jds_dir_t r;
		r = DIR_REST;
		case (prev)
			DIR_MINUS: begin
				if (s < lm) r = DIR_MINUS;
			end
			DIR_PLUS: begin
				if (s > hm) r = DIR_PLUS;
			end
			default: begin
				if (s < lr) r = DIR_MINUS;
				else if (s > hr) r = DIR_PLUS;
			end
		endcase
		return r;
	endfunction

	function automatic jds_dir_t flip(input jds_dir_t d, input logic en);
		jds_dir_t r;
		r = d;
		if (en) begin
			case (d)
				DIR_MINUS: r = DIR_PLUS;
				DIR_PLUS:  r = DIR_MINUS;
				default:   r = DIR_REST;
			endcase
		end
		return r;
	endfunction

	always_comb begin
		c19 = $signed({3'b000, cfg_q.center});
		d19 = $signed({3'b000, cfg_q.deadzone});
		h19 = $signed({3'b000, cfg_q.hyst});
		// widened band at rest, narrowed band while deflected
		lo_rest = c19 - (d19 + h19);
		hi_rest = c19 + (d19 + h19);
		lo_move = c19 - (d19 - h19);
		hi_move = c19 + (d19 - h19);
		sx = $signed({{(THR_W-SAMPLE_W){poll.x_sample[SAMPLE_W-1]}}, poll.x_sample});
		sy = $signed({{(THR_W-SAMPLE_W){poll.y_sample[SAMPLE_W-1]}}, poll.y_sample});
		hx = classify(sx, hdir_q, lo_rest, hi_rest, lo_move, hi_move);
		vy = classify(sy, vdir_q, lo_rest, hi_rest, lo_move, hi_move);
		ex = flip(hx, cfg_q.inv_h);
		ey = flip(vy, cfg_q.inv_v);
		stick[0] = (ey == DIR_MINUS);
		stick[1] = (ey == DIR_PLUS);
		stick[2] = (ex == DIR_MINUS);
		stick[3] = (ex == DIR_PLUS);
		for (int i = 0; i < BUTTON_LINES; i++) begin
			btn_en[i] = poll.button_levels[i] && (5'(i) < cfg_q.btn_total);
		end
		// columns past the top fall off the shift
		btn_wide  = 64'(btn_en) << cfg_q.btn_base;
		next_mask = btn_wide[MAX_COLUMNS-1:0] | MAX_COLUMNS'(stick);
		limit = 7'(cfg_q.btn_base) + 7'(cfg_q.btn_total);
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			in_range[i] = (7'(i) < limit);
		end
	end

	assign poll.ready  = !q_stat.full;
	assign accept      = poll.valid && poll.ready;
	assign push_report = (mask_q ^ next_mask) & in_range;
	assign push_level  = next_mask;
	assign push        = accept && (push_report != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{center: RST_CENTER, deadzone: RST_DEADZONE, hyst: RST_HYST,
				inv_h: 1'b0, inv_v: 1'b0, btn_base: RST_BTN_BASE,
				btn_total: RST_BTN_TOTAL};
			hdir_q <= DIR_REST;
			vdir_q <= DIR_REST;
			mask_q <= '0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_CENTER:    cfg_q.center    <= cfg_data;
					REG_DEADZONE:  cfg_q.deadzone  <= cfg_data;
					REG_HYST:      cfg_q.hyst      <= cfg_data;
					REG_INV_H:     cfg_q.inv_h     <= cfg_data[0];
					REG_INV_V:     cfg_q.inv_v     <= cfg_data[0];
					REG_BTN_BASE:  cfg_q.btn_base  <= cfg_data[5:0];
					REG_BTN_TOTAL: cfg_q.btn_total <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (accept) begin
				// hysteresis state is kept before inversion
				hdir_q <= hx;
				vdir_q <= vy;
				mask_q <= next_mask;
			end
		end
	end

endmodule

// ===== rtl/core/jds_queue.sv =====
// Small register FIFO between front and back ends.
// Depends on jds_pkg.
module jds_queue import jds_pkg::*; #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output jds_q_stat_t      stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rd_data    = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/jds_back.sv =====
// Back end: walks a change mask lowest column first, one event per cycle while
// the output slot is free, into a registered output. Depends on jds_pkg, jds_event_if.
module jds_back import jds_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MAX_COLUMNS-1:0] head_report,
	input  logic [MAX_COLUMNS-1:0] head_level,
	input  jds_q_stat_t            q_stat,
	output logic                   pop,
	jds_event_if.source            ev
);

	logic [MAX_COLUMNS-1:0] work_q, level_q, work_after;
	logic                   ev_valid_q, ev_pressed_q, ev_last_q;
	logic [COL_W-1:0]       ev_col_q;
	logic                   slot_free, emit;
	logic [COL_W-1:0]       idx;
	logic                   pressed;

	always_comb begin
		idx     = '0;
		pressed = 1'b0;
		for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
			if (work_q[i]) begin
				idx     = COL_W'(i);
				pressed = level_q[i];
			end
		end
	end

	assign slot_free  = !ev_valid_q || ev.ready;
	assign emit       = slot_free && (work_q != '0);
	// clear the lowest set bit
	assign work_after = emit ? (work_q & (work_q - 1'b1)) : work_q;
	assign pop        = (work_after == '0) && !q_stat.empty;

	assign ev.valid        = ev_valid_q;
	assign ev.column_index = ev_col_q;
	assign ev.is_pressed   = ev_pressed_q;
	assign ev.last_event   = ev_last_q;

	always_ff @(posedge clk) begin
		if (pop) level_q <= head_level;
		if (emit) begin
			ev_col_q     <= idx;
			ev_pressed_q <= pressed;
			ev_last_q    <= (work_after == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q     <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			work_q <= pop ? head_report : work_after;
			if (emit) ev_valid_q <= 1'b1;
			else if (ev.ready) ev_valid_q <= 1'b0;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for joystick_direction_scanner: directed polls, then random phases.
// Key events are predicted per accepted poll and matched in order against the event channel.
// Depends on jds_pkg, jds_poll_if, jds_event_if and the scanner RTL.
module testbench;
	import jds_pkg::*;

	localparam int MASK_COLUMNS    = 32;
	localparam int USE_MODEL       = -1;
	localparam int DRAIN_SLACK     = 8;
	localparam int LONG_HOLD       = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int MAX_IDLE        = 17;
	localparam int LIMIT_UNITS     = 2_000_000;

	typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [COL_W-1:0] column_index;
		logic             is_pressed;
		logic             last_event;
	} key_event_t;

	typedef struct {
		row_kind_t                  kind;
		logic [CFG_IDX_W-1:0]       reg_index;
		logic [CFG_DATA_W-1:0]      reg_value;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic [BUTTON_LINES-1:0]    buttons;
		int                         typed_n;
		key_event_t                 typed_ev;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jds_poll_if  poll_ch ();
	jds_event_if ev_ch ();

	joystick_direction_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.poll         (poll_ch),
		.ev           (ev_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	jds_cfg_t    model_cfg;
	logic [31:0] column_mask;
	jds_dir_t    horiz_dir;
	jds_dir_t    vert_dir;

	key_event_t  scan_events[$];
	key_event_t  expected_events[$];
	stim_row_t   directed_rows[$];

	int          typed_count = USE_MODEL;
	key_event_t  typed_event;
	logic [BUTTON_LINES-1:0] held_buttons = '0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          hold_off_req = 1'b0;
	bit          failed = 1'b0;

	function automatic jds_dir_t classify_axis(logic signed [SAMPLE_W-1:0] s, jds_dir_t prev);
		int smp, c, d, h;
		smp = s;
		c = model_cfg.center;
		d = model_cfg.deadzone;
		h = model_cfg.hyst;
		case (prev)
			DIR_MINUS: return (smp < c - (d - h)) ? DIR_MINUS : DIR_REST;
			DIR_PLUS:  return (smp > c + (d - h)) ? DIR_PLUS : DIR_REST;
			default: begin
				if (smp < c - (d + h))
					return DIR_MINUS;
				if (smp > c + (d + h))
					return DIR_PLUS;
				return DIR_REST;
			end
		endcase
	endfunction

	function automatic jds_dir_t mirror_dir(jds_dir_t dir, logic inv);
		if (!inv)
			return dir;
		case (dir)
			DIR_MINUS: return DIR_PLUS;
			DIR_PLUS:  return DIR_MINUS;
			default:   return DIR_REST;
		endcase
	endfunction

	// fills scan_events with the key changes one poll causes and advances the state
	function automatic void scan_poll(logic signed [SAMPLE_W-1:0] xs,
			logic signed [SAMPLE_W-1:0] ys, logic [BUTTON_LINES-1:0] levels);
		jds_dir_t hx, vy, ex, ey;
		logic [31:0] next_mask, changed;
		key_event_t evt;
		int count, limit, col;
		scan_events.delete();
		hx = classify_axis(xs, horiz_dir);
		vy = classify_axis(ys, vert_dir);
		ex = mirror_dir(hx, model_cfg.inv_h);
		ey = mirror_dir(vy, model_cfg.inv_v);
		next_mask = '0;
		if (ey == DIR_MINUS)
			next_mask[0] = 1'b1;
		else if (ey == DIR_PLUS)
			next_mask[1] = 1'b1;
		if (ex == DIR_MINUS)
			next_mask[2] = 1'b1;
		else if (ex == DIR_PLUS)
			next_mask[3] = 1'b1;
		count = (model_cfg.btn_total > BUTTON_LINES) ? BUTTON_LINES : model_cfg.btn_total;
		for (int i = 0; i < count; i++) begin
			col = model_cfg.btn_base + i;
			if (col < MASK_COLUMNS && levels[i])
				next_mask[col] = 1'b1;
		end
		limit = model_cfg.btn_base + model_cfg.btn_total;
		if (limit > MASK_COLUMNS)
			limit = MASK_COLUMNS;
		// changes at or above the limit still land in the mask, silently
		changed = column_mask ^ next_mask;
		for (int i = 0; i < limit; i++) begin
			if (changed[i]) begin
				evt.column_index = COL_W'(i);
				evt.is_pressed = next_mask[i];
				evt.last_event = 1'b0;
				scan_events.push_back(evt);
			end
		end
		if (scan_events.size() > 0)
			scan_events[scan_events.size() - 1].last_event = 1'b1;
		column_mask = next_mask;
		horiz_dir = hx;
		vert_dir = vy;
	endfunction

	always @(posedge clk) begin : monitor
		key_event_t want;
		if (arst_n === 1'b1) begin
			if (poll_ch.valid === 1'b1 && poll_ch.ready === 1'b1) begin
				scan_poll(poll_ch.x_sample, poll_ch.y_sample, poll_ch.button_levels);
				if (typed_count == USE_MODEL) begin
					foreach (scan_events[i])
						expected_events.push_back(scan_events[i]);
				end else begin
					for (int i = 0; i < typed_count; i++)
						expected_events.push_back(typed_event);
				end
			end
			if (ev_ch.valid === 1'b1 && ev_ch.ready === 1'b1) begin
				if (expected_events.size() == 0) begin
					$error("unexpected key event: column_index %0d is_pressed %0d",
						ev_ch.column_index, ev_ch.is_pressed);
					failed = 1'b1;
				end else begin
					want = expected_events.pop_front();
					if (ev_ch.column_index !== want.column_index) begin
						$error("column_index expected %0d got %0d",
							want.column_index, ev_ch.column_index);
						failed = 1'b1;
					end
					if (ev_ch.is_pressed !== want.is_pressed) begin
						$error("is_pressed expected %0d got %0d",
							want.is_pressed, ev_ch.is_pressed);
						failed = 1'b1;
					end
					if (ev_ch.last_event !== want.last_event) begin
						$error("last_event expected %0d got %0d",
							want.last_event, ev_ch.last_event);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// event sink: random stalls, plus one long hold-off on request
	initial begin : event_sink
		int stall;
		ev_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				stall = LONG_HOLD;
				hold_off_req = 1'b0;
			end else begin
				stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			end
			if (stall > 0) begin
				ev_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			ev_ch.ready <= 1'b1;
			do @(posedge clk); while (ev_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	function automatic void add_poll(int x, int y, logic [BUTTON_LINES-1:0] b, int n_typed,
			int col, logic pressed);
		stim_row_t r;
		r.kind = ROW_POLL;
		r.reg_index = REG_CENTER;
		r.reg_value = '0;
		r.x = SAMPLE_W'(x);
		r.y = SAMPLE_W'(y);
		r.buttons = b;
		r.typed_n = n_typed;
		r.typed_ev.column_index = COL_W'(col);
		r.typed_ev.is_pressed = pressed;
		r.typed_ev.last_event = 1'b1;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int value);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.reg_index = idx;
		r.reg_value = CFG_DATA_W'(value);
		r.x = '0;
		r.y = '0;
		r.buttons = '0;
		r.typed_n = USE_MODEL;
		r.typed_ev = '0;
		directed_rows.push_back(r);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_CENTER:    model_cfg.center = value;
			REG_DEADZONE:  model_cfg.deadzone = value;
			REG_HYST:      model_cfg.hyst = value;
			REG_INV_H:     model_cfg.inv_h = value[0];
			REG_INV_V:     model_cfg.inv_v = value[0];
			REG_BTN_BASE:  model_cfg.btn_base = value[5:0];
			REG_BTN_TOTAL: model_cfg.btn_total = value[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic offer_poll(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
			logic [BUTTON_LINES-1:0] b, int n_typed, key_event_t tev);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			poll_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_count = n_typed;
		typed_event = tev;
		poll_ch.valid <= 1'b1;
		poll_ch.x_sample <= x;
		poll_ch.y_sample <= y;
		poll_ch.button_levels <= b;
		do @(posedge clk); while (poll_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// polls without events are never queued; the slack only adds idle time
	task automatic drain_idle();
		poll_ch.valid <= 1'b0;
		while (expected_events.size() > 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] stick_sample();
		int c, d, h, v, pick;
		c = model_cfg.center;
		d = model_cfg.deadzone;
		h = model_cfg.hyst;
		pick = $urandom_range(0, 9);
		case (pick)
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = c;
			2: v = c - (d + h);
			3: v = c + (d + h);
			4: v = c - (d - h);
			5: v = c + (d - h);
			6: v = c - d;
			7: v = c + d;
			default: v = c + int'($urandom_range(0, 2 * (d + h) + 2)) - (d + h + 1);
		endcase
		if (pick != 0)
			v = v + int'($urandom_range(0, 6)) - 3;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return SAMPLE_W'(v);
	endfunction

	// mostly a few buttons toggle per poll, sometimes a fresh random set
	function automatic logic [BUTTON_LINES-1:0] next_buttons();
		if ($urandom_range(0, 4) == 0)
			held_buttons = BUTTON_LINES'($urandom);
		else
			repeat ($urandom_range(0, 3))
				held_buttons[$urandom_range(0, BUTTON_LINES - 1)] ^= 1'b1;
		return held_buttons;
	endfunction

	task automatic configure_phase(bit extreme);
		logic [15:0] c, d, h;
		int base, total;
		if (extreme) begin
			c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			base = $urandom_range(0, 1) ? 63 : 0;
			total = $urandom_range(0, 1) ? 31 : 0;
		end else begin
			c = 16'($urandom_range(0, 40000));
			d = 16'($urandom_range(0, 3000));
			h = 16'($urandom_range(0, 1500));
			base = ($urandom_range(0, 7) == 0) ? $urandom_range(35, 63) : $urandom_range(0, 34);
			total = $urandom_range(0, 31);
		end
		write_reg(REG_CENTER, c);
		write_reg(REG_DEADZONE, d);
		write_reg(REG_HYST, h);
		write_reg(REG_INV_H, 16'($urandom));
		write_reg(REG_INV_V, 16'($urandom));
		write_reg(REG_BTN_BASE, {10'($urandom), 6'(base)});
		write_reg(REG_BTN_TOTAL, {11'($urandom), 5'(total)});
	endtask

	initial begin : stimulus
		key_event_t no_event;
		no_event = '0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_CENTER;
		cfg_data = '0;
		poll_ch.valid = 1'b0;
		poll_ch.x_sample = '0;
		poll_ch.y_sample = '0;
		poll_ch.button_levels = '0;
		model_cfg = '{center: RST_CENTER, deadzone: RST_DEADZONE, hyst: RST_HYST,
			inv_h: 1'b0, inv_v: 1'b0, btn_base: RST_BTN_BASE, btn_total: RST_BTN_TOTAL};
		column_mask = '0;
		horiz_dir = DIR_REST;
		vert_dir = DIR_REST;

		// reset settings: only the stick columns report
		add_poll(2048, 2048, 28'h0, 0, 0, 1'b0);
		add_poll(2048, -32768, 28'h0, 1, 0, 1'b1);
		add_poll(2048, 1850, 28'h0, 0, 0, 1'b0);        // inside hysteresis, still down
		add_poll(2048, 1950, 28'h0, 1, 0, 1'b0);
		add_poll(2048, 32767, 28'h0, 1, 1, 1'b1);
		add_poll(2048, 2250, 28'h0, 0, 0, 1'b0);
		add_poll(2048, 2048, 28'h0, 1, 1, 1'b0);
		add_poll(-32768, 2048, 28'h0, 1, 2, 1'b1);
		add_poll(32767, 2048, 28'h0, 1, 2, 1'b0);       // full swing passes through rest
		add_poll(32767, 2048, 28'h0, 1, 3, 1'b1);
		add_poll(2048, 2048, 28'hFFFFFFF, 1, 3, 1'b0);  // buttons unused at count zero
		add_cfg(REG_INV_H, 1);
		add_cfg(REG_INV_V, 1);
		add_cfg(REG_BTN_TOTAL, 28);
		add_poll(2048, 2048, 28'hFFFFFFF, USE_MODEL, 0, 1'b0);
		add_poll(-32768, -32768, 28'h0, USE_MODEL, 0, 1'b0);
		add_poll(2048, 2048, 28'hAAAAAAA, USE_MODEL, 0, 1'b0);
		// buttons overlapping stick columns, count above 28
		add_cfg(REG_BTN_BASE, 2);
		add_cfg(REG_BTN_TOTAL, 31);
		add_poll(-32768, 32767, 28'hFFFFFFF, USE_MODEL, 0, 1'b0);
		// hysteresis wider than deadzone: leave threshold past center
		add_cfg(REG_DEADZONE, 0);
		add_cfg(REG_HYST, 65535);
		add_poll(32767, -32768, 28'h0, USE_MODEL, 0, 1'b0);
		add_cfg(REG_HYST, 0);
		add_cfg(REG_CENTER, 65535);
		add_cfg(REG_DEADZONE, 65535);
		add_poll(0, 0, 28'h0, USE_MODEL, 0, 1'b0);
		add_poll(-1, -32768, 28'h5555555, USE_MODEL, 0, 1'b0);
		// buttons all beyond the last column
		add_cfg(REG_CENTER, 0);
		add_cfg(REG_DEADZONE, 0);
		add_cfg(REG_BTN_BASE, 63);
		add_poll(0, 0, 28'hFFFFFFF, USE_MODEL, 0, 1'b0);
		add_poll(1, -1, 28'hFFFFFFF, USE_MODEL, 0, 1'b0);
		add_poll(32767, 32767, 28'h0, USE_MODEL, 0, 1'b0);
		add_cfg(REG_BTN_BASE, 32);
		add_cfg(REG_BTN_TOTAL, 0);
		add_poll(-32768, -32768, 28'hFFFFFFF, USE_MODEL, 0, 1'b0);
		// narrow report range: stick changes above it are absorbed
		add_cfg(REG_BTN_BASE, 0);
		add_cfg(REG_BTN_TOTAL, 2);
		add_cfg(REG_INV_H, 0);
		add_cfg(REG_INV_V, 0);
		add_poll(-32768, 2048, 28'h3, USE_MODEL, 0, 1'b0);
		add_poll(2048, 2048, 28'h0, USE_MODEL, 0, 1'b0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_idle();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
			end else begin
				offer_poll(directed_rows[i].x, directed_rows[i].y, directed_rows[i].buttons,
					directed_rows[i].typed_n, directed_rows[i].typed_ev);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_idle();
			configure_phase(p % 3 == 2);
			tx_idle_on = (p != 1) && (p != 5);
			rx_idle_on = (p != 3) && (p != 5);
			// back-to-back requests against a stalled sink fill the queue
			if (p == 1)
				hold_off_req = 1'b1;
			repeat (ITEMS_PER_PHASE)
				offer_poll(stick_sample(), stick_sample(), next_buttons(), USE_MODEL, no_event);
		end

		drain_idle();
		if (failed)
			$display("SCOREBOARD MISMATCH");
		else
			$display("SCOREBOARD CLEAN");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_UNITS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
